[hdl/backoff_rule_scheduler_unit_assert.svh]
// ----------------------------------------------------------------------------
// backoff rule scheduler assertion macros
// concurrent checks that vanish in synthesis builds
// ----------------------------------------------------------------------------
`ifndef BACKOFF_RULE_SCHEDULER_UNIT_ASSERT_SVH
`define BACKOFF_RULE_SCHEDULER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// check with reset disabling the property
`define BRS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("backoff rule scheduler check failed");

// check that also holds across reset
`define BRS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("backoff rule scheduler check failed");

`else

`define BRS_ASSERT(lbl, clk, rst_n, prop)
`define BRS_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[hdl/brs_pkg.sv]
// ----------------------------------------------------------------------------
// backoff rule scheduler package
// opcodes, transaction types and shared helpers
// ----------------------------------------------------------------------------
package brs_pkg;

    localparam int OP_W   = 2;
    localparam int IDX_W  = 6;
    localparam int WORD_W = 32;

    localparam logic [OP_W-1:0] OP_INIT   = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_REPORT = 2'd2;

    localparam logic [WORD_W-1:0] WORD_SAT = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_ONE = 32'd1;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [IDX_W-1:0]  rule_index;
        logic [WORD_W-1:0] match_count;
        logic [WORD_W-1:0] initial_limit;
    } t_in_item;

    typedef struct packed {
        logic              is_banned;
        logic [WORD_W-1:0] apply_count;
        logic [WORD_W-1:0] head_take;
        logic [WORD_W-1:0] tail_start;
        logic              throttled;
    } t_out_item;

    // per rule backoff state, set to STATE_RESET after reset
    typedef struct packed {
        logic [WORD_W-1:0] ban_countdown;
        logic [WORD_W-1:0] next_ban_length;
    } t_rule_state;

    localparam t_rule_state STATE_RESET = '{ban_countdown: '0, next_ban_length: WORD_ONE};

    // write request from the update logic to the rule table
    typedef struct packed {
        logic              state_we;
        logic              budget_we;
        logic [IDX_W-1:0]  addr;
        t_rule_state       state;
        logic [WORD_W-1:0] budget;
    } t_tbl_wr;

    function automatic logic [WORD_W-1:0] sat_double(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        if (v[WORD_W-1]) begin
            r = WORD_SAT;
        end else begin
            r = {v[WORD_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

[hdl/brs_table.sv]
// ----------------------------------------------------------------------------
// backoff rule scheduler rule table
// per rule state and budget memories with registered read and clearing pass
// ----------------------------------------------------------------------------
`include "backoff_rule_scheduler_unit_assert.svh"

module brs_table #(
    parameter int DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [brs_pkg::IDX_W-1:0]    i_rd_addr,
    input  brs_pkg::t_tbl_wr             i_wr,
    output brs_pkg::t_rule_state         o_rd_state,
    output logic [brs_pkg::WORD_W-1:0]   o_rd_budget,
    output logic                         o_clr_busy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    brs_pkg::t_rule_state        mem_state  [DEPTH];
    logic [brs_pkg::WORD_W-1:0]  mem_budget [DEPTH];

    logic                        r_clr_busy;
    logic [AW-1:0]               r_clr_addr;
    brs_pkg::t_rule_state        r_rd_state;
    logic [brs_pkg::WORD_W-1:0]  r_rd_budget;

    logic [AW-1:0]               s_wr_addr;
    logic [AW-1:0]               s_rd_addr;
    logic                        s_same;

    assign s_wr_addr = i_wr.addr[AW-1:0];
    assign s_rd_addr = i_rd_addr[AW-1:0];
    assign s_same    = (s_wr_addr == s_rd_addr);

    // clearing pass over the state memory after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem_state[r_clr_addr] <= brs_pkg::STATE_RESET;
        end else if (i_wr.state_we) begin
            mem_state[s_wr_addr] <= i_wr.state;
        end
        if (i_wr.budget_we) begin
            mem_budget[s_wr_addr] <= i_wr.budget;
        end
    end

    // write-through on a same-edge hit so back-to-back updates chain
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_state  <= (i_wr.state_we && s_same) ? i_wr.state : mem_state[s_rd_addr];
            r_rd_budget <= (i_wr.budget_we && s_same) ? i_wr.budget : mem_budget[s_rd_addr];
        end
    end

    assign o_rd_state  = r_rd_state;
    assign o_rd_budget = r_rd_budget;
    assign o_clr_busy  = r_clr_busy;

    `BRS_ASSERT_ALWAYS(a_clr_after_reset, i_clk, !i_rst_n |=> r_clr_busy)
    `BRS_ASSERT(a_no_item_write_in_clr, i_clk, i_rst_n,
        r_clr_busy |-> !i_wr.state_we && !i_wr.budget_we && !i_rd_en)
    `BRS_ASSERT(a_clr_addr_steps, i_clk, i_rst_n,
        r_clr_busy && r_clr_addr != LAST_ADDR |=> r_clr_addr == $past(r_clr_addr) + AW'(1))

endmodule

[hdl/brs_alu.sv]
// ----------------------------------------------------------------------------
// backoff rule scheduler update logic
// decodes one transaction against the rule state, forms result and write back
// ----------------------------------------------------------------------------
module brs_alu (
    input  logic                        i_backoff_enable,
    input  brs_pkg::t_in_item           i_item,
    input  logic                        i_hit,
    input  brs_pkg::t_rule_state        i_state,
    input  logic [brs_pkg::WORD_W-1:0]  i_budget,
    output brs_pkg::t_out_item          o_result,
    output brs_pkg::t_tbl_wr            o_wr
);

    logic [brs_pkg::WORD_W-1:0] s_eff_budget;
    logic [brs_pkg::WORD_W-1:0] s_half;
    logic [brs_pkg::WORD_W-1:0] s_upper;
    logic [brs_pkg::WORD_W-1:0] s_nbl_half;
    logic                       s_over;

    assign s_eff_budget = i_backoff_enable ? i_budget : i_item.match_count;
    assign s_over       = (i_item.match_count > s_eff_budget);
    assign s_half       = s_eff_budget >> 1;
    // upper half of the budget, rounded up
    assign s_upper      = s_half + {{(brs_pkg::WORD_W-1){1'b0}}, s_eff_budget[0]};
    assign s_nbl_half   = i_state.next_ban_length >> 1;

    always_comb begin
        o_result       = '0;
        o_wr           = '0;
        o_wr.addr      = i_item.rule_index;
        o_wr.state     = i_state;
        o_wr.budget    = i_budget;
        if (i_hit) begin
            unique case (i_item.opcode)
                brs_pkg::OP_INIT: begin
                    o_wr.state_we  = 1'b1;
                    o_wr.budget_we = 1'b1;
                    o_wr.state     = brs_pkg::STATE_RESET;
                    o_wr.budget    = i_item.initial_limit;
                end
                brs_pkg::OP_QUERY: begin
                    if (i_backoff_enable && (i_state.ban_countdown != '0)) begin
                        o_result.is_banned       = 1'b1;
                        o_wr.state_we            = 1'b1;
                        o_wr.state.ban_countdown = i_state.ban_countdown
                                                   - brs_pkg::WORD_ONE;
                    end
                end
                brs_pkg::OP_REPORT: begin
                    if (s_over) begin
                        o_result.apply_count       = s_eff_budget;
                        o_result.head_take         = s_half;
                        o_result.tail_start        = i_item.match_count - s_upper;
                        o_result.throttled         = 1'b1;
                        o_wr.state_we              = 1'b1;
                        o_wr.budget_we             = 1'b1;
                        o_wr.state.ban_countdown   = i_state.next_ban_length;
                        o_wr.state.next_ban_length =
                            brs_pkg::sat_double(i_state.next_ban_length);
                        o_wr.budget                = brs_pkg::sat_double(i_budget);
                    end else begin
                        o_result.apply_count = i_item.match_count;
                        o_result.head_take   = i_item.match_count;
                        o_result.tail_start  = i_item.match_count;
                        if (i_backoff_enable) begin
                            o_wr.state_we              = 1'b1;
                            o_wr.state.next_ban_length = (s_nbl_half == '0)
                                                         ? brs_pkg::WORD_ONE : s_nbl_half;
                        end
                    end
                end
                default: begin
                    // unused opcode leaves everything untouched
                end
            endcase
        end
    end

endmodule

[hdl/backoff_rule_scheduler_unit.sv]
// an accepted input transaction goes through the front stage, then the result register, to o_m_tvalid
// throughput: one transaction and one rule table read-modify-write per cycle while not stalled
// the result register decouples the sides; i_m_tready low stalls the one-entry front stage
// reset: synchronous, active low; then a clearing pass over min(NUM_RULES, 64) entries
// walks the rule state memory with o_s_tready held low; config writes are always taken
// ----------------------------------------------------------------------------
// backoff rule scheduler top level
// per rule ban countdown, ban length and match budget with throttled match reporting
// ----------------------------------------------------------------------------
`include "backoff_rule_scheduler_unit_assert.svh"

module backoff_rule_scheduler_unit #(
    parameter int NUM_RULES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,

    // configuration write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data,      // backoff_enable

    // input transactions
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [71:0]  i_s_tdata,       // rule_index[5:0], match_count[37:6],
                                          // initial_limit[69:38], zero pad[71:70]
    input  logic [1:0]   i_s_tuser,       // opcode[1:0]

    // result transactions
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [95:0]  o_m_tdata,       // apply_count[31:0], head_take[63:32],
                                          // tail_start[95:64]
    output logic [1:0]   o_m_tuser        // is_banned[0], throttled[1]
);

    // only the first 64 rules are reachable through a 6-bit index
    localparam int DEPTH = (NUM_RULES < 64) ? NUM_RULES : 64;

    // config register
    logic                        r_backoff_enable;

    // front stage: captured transaction, table read lands alongside
    logic                        r_s1_valid;
    brs_pkg::t_in_item           r_s1_item;
    logic                        r_s1_hit;

    // result register
    logic                        r_out_valid;
    brs_pkg::t_out_item          r_out;

    brs_pkg::t_in_item           s_in_item;
    brs_pkg::t_rule_state        s_rd_state;
    logic [brs_pkg::WORD_W-1:0]  s_rd_budget;
    logic                        s_clr_busy;
    brs_pkg::t_out_item          s_result;
    brs_pkg::t_tbl_wr            s_alu_wr;
    brs_pkg::t_tbl_wr            s_tbl_wr;
    logic                        s_out_free;
    logic                        s_commit;
    logic                        s_accept;
    logic                        s_in_hit;

    // unpack the input transaction
    assign s_in_item.opcode        = i_s_tuser;
    assign s_in_item.rule_index    = i_s_tdata[5:0];
    assign s_in_item.match_count   = i_s_tdata[37:6];
    assign s_in_item.initial_limit = i_s_tdata[69:38];

    assign s_in_hit = ({26'd0, s_in_item.rule_index} < 32'(NUM_RULES));

    // handshake: the result register frees when drained, the front stage when it moves on
    assign s_out_free = !r_out_valid || i_m_tready;
    assign s_commit   = r_s1_valid && s_out_free;
    assign o_s_tready = (!r_s1_valid || s_out_free) && !s_clr_busy;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backoff_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            r_backoff_enable <= i_cfg_data;
        end
    end

    // front stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s_commit) begin
            r_s1_valid <= 1'b0;
        end
    end

    // front stage payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_item <= s_in_item;
            r_s1_hit  <= s_in_hit;
        end
    end

    // table writes happen as the front stage hands its result on
    always_comb begin
        s_tbl_wr           = s_alu_wr;
        s_tbl_wr.state_we  = s_alu_wr.state_we && s_commit;
        s_tbl_wr.budget_we = s_alu_wr.budget_we && s_commit;
    end

    brs_table #(
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (s_accept),
        .i_rd_addr   (s_in_item.rule_index),
        .i_wr        (s_tbl_wr),
        .o_rd_state  (s_rd_state),
        .o_rd_budget (s_rd_budget),
        .o_clr_busy  (s_clr_busy)
    );

    brs_alu u_alu (
        .i_backoff_enable (r_backoff_enable),
        .i_item           (r_s1_item),
        .i_hit            (r_s1_hit),
        .i_state          (s_rd_state),
        .i_budget         (s_rd_budget),
        .o_result         (s_result),
        .o_wr             (s_alu_wr)
    );

    // result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_commit) begin
            r_out <= s_result;
        end
    end

    // pack the result transaction
    assign o_m_tvalid       = r_out_valid;
    assign o_m_tdata[31:0]  = r_out.apply_count;
    assign o_m_tdata[63:32] = r_out.head_take;
    assign o_m_tdata[95:64] = r_out.tail_start;
    assign o_m_tuser[0]     = r_out.is_banned;
    assign o_m_tuser[1]     = r_out.throttled;

    `BRS_ASSERT(a_stalled_stage_kept, i_clk, i_rst_n,
        r_s1_valid && !s_out_free |=> r_s1_valid && $stable(r_s1_item))
    `BRS_ASSERT(a_banned_result_empty, i_clk, i_rst_n,
        r_out_valid && r_out.is_banned |-> r_out.apply_count == '0 && !r_out.throttled)
    `BRS_ASSERT(a_throttle_head_bound, i_clk, i_rst_n,
        r_out_valid && r_out.throttled |-> r_out.head_take <= r_out.apply_count)
    `BRS_ASSERT(a_no_accept_in_clear, i_clk, i_rst_n,
        s_clr_busy |=> !r_s1_valid || $past(r_s1_valid))

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// backoff rule scheduler testbench
// streams rule events into the unit under random idling and stalls, predicts
// each ban query and match report outcome from a shadow rule table and
// compares every result transaction field by field
// ----------------------------------------------------------------------------
module tb_top;

    // opcode the unit ignores
    localparam logic [brs_pkg::OP_W-1:0] OP_SPARE = 2'd3;
    localparam int RULES = 64;

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_data  = 1'b0;
    logic         i_s_tvalid  = 1'b0;
    logic         o_s_tready;
    logic [71:0]  i_s_tdata   = '0;   // rule_index, match_count, initial_limit, pad
    logic [1:0]   i_s_tuser   = '0;   // opcode
    logic         o_m_tvalid;
    logic         i_m_tready  = 1'b0;
    logic [95:0]  o_m_tdata;          // apply_count, head_take, tail_start
    logic [1:0]   o_m_tuser;          // is_banned, throttled

    backoff_rule_scheduler_unit #(
        .NUM_RULES (RULES)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #10 i_clk = ~i_clk;

    // shadow rule table and register
    logic [brs_pkg::WORD_W-1:0] countdown_tbl [RULES];
    logic [brs_pkg::WORD_W-1:0] ban_len_tbl   [RULES];
    logic [brs_pkg::WORD_W-1:0] budget_tbl    [RULES];
    logic                       rule_live     [RULES];   // budget loaded at least once
    logic                       cfg_enable;

    brs_pkg::t_in_item  event_q[$];      // rule events waiting to be sent
    brs_pkg::t_out_item outcome_q[$];    // predicted outcomes in flight

    brs_pkg::t_in_item  src_item;
    logic               src_live  = 1'b0;
    int                 src_gap   = 0;
    int                 src_odds  = 6;
    int                 src_tick  = 0;
    int                 n_sent    = 0;

    brs_pkg::t_out_item got_res;
    brs_pkg::t_out_item want_res;
    int                 sink_gap  = 0;
    int                 sink_odds = 6;
    int                 sink_tick = 0;
    int                 n_recv    = 0;
    logic               sink_hold = 1'b0;

    logic               no_idle   = 1'b0;
    int                 n_fail    = 0;

    function automatic logic [brs_pkg::WORD_W-1:0] twice_capped(
        input logic [brs_pkg::WORD_W-1:0] v);
        if (v > 32'h7FFF_FFFF) begin
            return '1;
        end
        return v << 1;
    endfunction

    // applies one rule event to the shadow table and returns its outcome
    function automatic brs_pkg::t_out_item backoff_outcome(input brs_pkg::t_in_item ev);
        brs_pkg::t_out_item         res;
        logic [brs_pkg::WORD_W-1:0] cnt;
        logic [brs_pkg::WORD_W-1:0] eff;
        logic [brs_pkg::WORD_W-1:0] half;
        int                         r;
        res  = '0;
        r    = int'(ev.rule_index);
        cnt  = ev.match_count;
        case (ev.opcode)
            brs_pkg::OP_INIT: begin
                budget_tbl[r]    = ev.initial_limit;
                countdown_tbl[r] = '0;
                ban_len_tbl[r]   = 32'd1;
            end
            brs_pkg::OP_QUERY: begin
                if (cfg_enable && countdown_tbl[r] != 0) begin
                    countdown_tbl[r] = countdown_tbl[r] - 32'd1;
                    res.is_banned    = 1'b1;
                end
            end
            brs_pkg::OP_REPORT: begin
                eff = cfg_enable ? budget_tbl[r] : cnt;
                if (cnt <= eff) begin
                    res.apply_count = cnt;
                    res.head_take   = cnt;
                    res.tail_start  = cnt;
                    if (cfg_enable) begin
                        ban_len_tbl[r] = (ban_len_tbl[r] > 1) ? ban_len_tbl[r] >> 1 : 32'd1;
                    end
                end else begin
                    half             = eff >> 1;
                    res.apply_count  = eff;
                    res.head_take    = half;
                    res.tail_start   = cnt - (eff - half);
                    res.throttled    = 1'b1;
                    countdown_tbl[r] = ban_len_tbl[r];
                    ban_len_tbl[r]   = twice_capped(ban_len_tbl[r]);
                    budget_tbl[r]    = twice_capped(budget_tbl[r]);
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // idle odds for a stretch: often, rarely or practically never
    function automatic int pick_odds();
        case ($urandom_range(0, 2))
            0: return 2;
            1: return 10;
            default: return 1_000_000;
        endcase
    endfunction

    function automatic logic [brs_pkg::WORD_W-1:0] pick_limit();
        // a zero budget a third of the time
        if ($urandom_range(0, 2) == 0) begin
            return '0;
        end
        case ($urandom_range(0, 3))
            0: return $urandom_range(1, 16);
            1: return 32'h7FFF_FFFF + $urandom_range(0, 2);
            2: return $urandom;
            default: return '1;
        endcase
    endfunction

    function automatic logic [brs_pkg::WORD_W-1:0] pick_count(
        input logic [brs_pkg::WORD_W-1:0] lim, input logic hammer);
        logic [brs_pkg::WORD_W-1:0] c;
        case ($urandom_range(0, 5))
            0: c = '0;
            1: c = lim;
            2: c = lim + 32'd1;
            3: c = $urandom_range(0, 20);
            4: c = $urandom;
            default: c = '1;
        endcase
        if (hammer && c == 0) begin
            c = 32'd1;
        end
        return c;
    endfunction

    task automatic push_event(input logic [brs_pkg::OP_W-1:0] op, input int r,
                              input logic [brs_pkg::WORD_W-1:0] cnt,
                              input logic [brs_pkg::WORD_W-1:0] lim);
        brs_pkg::t_in_item ev;
        ev.opcode        = op;
        ev.rule_index    = r[brs_pkg::IDX_W-1:0];
        ev.match_count   = cnt;
        ev.initial_limit = lim;
        if (op == brs_pkg::OP_INIT) begin
            rule_live[r] = 1'b1;
        end
        event_q.insert(event_q.size(), ev);
    endtask

    // short hand-picked run with backoff on
    task automatic queue_directed();
        push_event(brs_pkg::OP_INIT,   0,  $urandom, 32'd4);
        push_event(brs_pkg::OP_REPORT, 0,  32'd4, $urandom);          // count equals budget
        push_event(brs_pkg::OP_REPORT, 0,  32'd5, $urandom);          // just over budget
        push_event(brs_pkg::OP_QUERY,  0,  $urandom, $urandom);       // banned for one round
        push_event(brs_pkg::OP_QUERY,  0,  $urandom, $urandom);
        push_event(brs_pkg::OP_REPORT, 0,  32'd0, $urandom);
        push_event(brs_pkg::OP_INIT,   63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_event(brs_pkg::OP_REPORT, 63, 32'hFFFF_FFFF, 32'd0);
        push_event(brs_pkg::OP_QUERY,  63, 32'd0, 32'hFFFF_FFFF);
        push_event(brs_pkg::OP_INIT,   42, 32'd0, 32'h8000_0001);
        push_event(brs_pkg::OP_REPORT, 42, 32'hFFFF_FFFF, $urandom);  // doubling saturates
        push_event(brs_pkg::OP_REPORT, 42, 32'hFFFF_FFFF, $urandom);
        push_event(brs_pkg::OP_INIT,   21, $urandom, 32'd0);
        push_event(brs_pkg::OP_REPORT, 21, 32'd1, $urandom);          // zero budget
        push_event(brs_pkg::OP_REPORT, 21, 32'hFFFF_FFFF, $urandom);
        push_event(brs_pkg::OP_QUERY,  21, $urandom, $urandom);
        push_event(brs_pkg::OP_QUERY,  21, $urandom, $urandom);
        push_event(brs_pkg::OP_QUERY,  21, $urandom, $urandom);
        push_event(brs_pkg::OP_REPORT, 21, 32'd0, $urandom);          // ban length halves
        push_event(OP_SPARE,           5,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_event(OP_SPARE,           58, 32'd0, 32'd0);
        push_event(brs_pkg::OP_QUERY,  42, $urandom, $urandom);
    endtask

    // mostly init-then-traffic runs on one rule, with some loose noise
    task automatic queue_events(input int n, input logic en);
        brs_pkg::t_in_item          ev;
        int                         left;
        int                         rl;
        int                         roll;
        logic [brs_pkg::WORD_W-1:0] lim;
        logic                       hammer;
        logic                       fresh;
        left   = 0;
        rl     = 0;
        lim    = '0;
        hammer = 1'b0;
        for (int k = 0; k < n; k++) begin
            fresh = 1'b0;
            if ($urandom_range(0, 9) == 0) begin
                roll             = $urandom_range(0, 3);
                ev.opcode        = roll[brs_pkg::OP_W-1:0];
                roll             = $urandom_range(0, RULES - 1);
                ev.rule_index    = roll[brs_pkg::IDX_W-1:0];
                ev.match_count   = $urandom;
                ev.initial_limit = $urandom;
            end else begin
                if (left == 0) begin
                    rl     = $urandom_range(0, RULES - 1);
                    left   = $urandom_range(4, 64);
                    hammer = ($urandom_range(0, 3) == 0);
                    lim    = pick_limit();
                    // an occasional run picks up where an older one left off
                    fresh  = ($urandom_range(0, 5) != 0) || !rule_live[rl];
                end
                ev.rule_index    = rl[brs_pkg::IDX_W-1:0];
                ev.initial_limit = fresh ? lim : $urandom;
                ev.match_count   = pick_count(lim, hammer);
                if (fresh) begin
                    ev.opcode = brs_pkg::OP_INIT;
                end else begin
                    ev.opcode = ($urandom_range(0, 9) < 4) ? brs_pkg::OP_QUERY
                                                          : brs_pkg::OP_REPORT;
                    left--;
                end
            end
            // a report must never read a budget that was never loaded
            if (en && ev.opcode == brs_pkg::OP_REPORT && !rule_live[ev.rule_index]) begin
                ev.opcode = brs_pkg::OP_INIT;
            end
            push_event(ev.opcode, int'(ev.rule_index), ev.match_count, ev.initial_limit);
        end
    endtask

    task automatic write_enable(input logic v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        cfg_enable = v;
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every event to be sent and every outcome to come back
    task automatic settle();
        while (event_q.size() > 0 || src_live || outcome_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // input side: one transaction offered at a time, valid held until taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                outcome_q.insert(outcome_q.size(), backoff_outcome(src_item));
                n_sent++;
                src_live = 1'b0;
            end
            src_tick++;
            if (src_tick % 97 == 0) begin
                src_odds = pick_odds();
            end
            if (!src_live) begin
                if (src_gap > 0) begin
                    src_gap--;
                end else if (event_q.size() > 0) begin
                    if (!no_idle && $urandom_range(0, src_odds) == 0) begin
                        src_gap = $urandom_range(1, 11) - 1;
                    end else begin
                        src_item = event_q.pop_front();
                        src_live = 1'b1;
                    end
                end
            end
            i_s_tvalid <= src_live;
            i_s_tdata  <= {2'b00, src_item.initial_limit, src_item.match_count,
                           src_item.rule_index};
            i_s_tuser  <= src_item.opcode;
        end
    end

    // result side: check each transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got_res.apply_count = o_m_tdata[31:0];
                got_res.head_take   = o_m_tdata[63:32];
                got_res.tail_start  = o_m_tdata[95:64];
                got_res.is_banned   = o_m_tuser[0];
                got_res.throttled   = o_m_tuser[1];
                if (outcome_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("result %0d arrived with nothing expected: tuser %b tdata %h",
                                 n_recv, o_m_tuser, o_m_tdata);
                    end
                end else begin
                    want_res = outcome_q.pop_front();
                    if (got_res.is_banned !== want_res.is_banned
                        || got_res.apply_count !== want_res.apply_count
                        || got_res.head_take !== want_res.head_take
                        || got_res.tail_start !== want_res.tail_start
                        || got_res.throttled !== want_res.throttled) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("result %0d want banned %b apply %h head %h tail %h thr %b",
                                     n_recv, want_res.is_banned, want_res.apply_count,
                                     want_res.head_take, want_res.tail_start,
                                     want_res.throttled);
                            $display("result %0d got  banned %b apply %h head %h tail %h thr %b",
                                     n_recv, got_res.is_banned, got_res.apply_count,
                                     got_res.head_take, got_res.tail_start,
                                     got_res.throttled);
                        end
                    end
                end
                n_recv++;
            end
            sink_tick++;
            if (sink_tick % 89 == 0) begin
                sink_odds = pick_odds();
            end
            if (sink_gap > 0) begin
                sink_gap--;
            end else if (!no_idle && $urandom_range(0, sink_odds) == 0) begin
                sink_gap = $urandom_range(1, 11);
            end
            i_m_tready <= !sink_hold && sink_gap == 0;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial begin
        wait (n_sent >= 400);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("FAIL backoff_rule_scheduler_unit");
        $finish;
    end

    initial begin
        int k;
        for (k = 0; k < RULES; k++) begin
            countdown_tbl[k] = '0;
            ban_len_tbl[k]   = 32'd1;
            budget_tbl[k]    = '0;
            rule_live[k]     = 1'b0;
        end
        cfg_enable = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_enable(1'b1);
        queue_directed();
        settle();

        write_enable(1'b0);
        queue_events(150, 1'b0);
        settle();

        write_enable(1'b1);
        queue_events(700, 1'b1);
        settle();

        write_enable(1'b0);
        queue_events(150, 1'b0);
        settle();

        write_enable(1'b1);
        queue_events(450, 1'b1);
        while (event_q.size() > 0) begin
            @(posedge i_clk);
        end
        // closing stretch at full rate on both sides
        no_idle <= 1'b1;
        queue_events(150, 1'b1);
        settle();

        if (n_fail == 0) begin
            $display("PASS backoff_rule_scheduler_unit");
        end else begin
            $display("FAIL backoff_rule_scheduler_unit");
        end
        $finish;
    end

endmodule
